// ===== sv/sesl_pkg.sv =====
package sesl_pkg;

   localparam int DEF_MAX_SECTORS = 64;

   localparam int COORD_W  = 8;
   localparam int AREA_W   = 2 * COORD_W;
   localparam int KIND_W   = 2;
   localparam int STATUS_W = 3;
   localparam int CODE_W   = 4;
   localparam int RANK_W   = 7;

   // item kinds
   localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_QUERY = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_ANSWERED = 3'd0;
   localparam logic [STATUS_W-1:0] ST_LOADED   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_SKIPPED  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd4;

   // third codes
   localparam logic [CODE_W-1:0] CODE_WEST  = 4'd8;
   localparam logic [CODE_W-1:0] CODE_EAST  = 4'd4;
   localparam logic [CODE_W-1:0] CODE_SOUTH = 4'd2;
   localparam logic [CODE_W-1:0] CODE_NORTH = 4'd1;

   // implicit catch-all rectangle
   localparam logic [COORD_W-1:0] CATCH_ALL_SIZE = 8'd255;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] w;
      logic [COORD_W-1:0] h;
      logic [COORD_W-1:0] sample;
   } sesl_entry_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [COORD_W-1:0]  found_sample;
      logic [CODE_W-1:0]   sub_location;
      logic                catch_all;
      logic [RANK_W-1:0]   entry_rank;
   } sesl_res_type;

   // Exact thirds test: 3*i against w and 2*w, no division needed.
   function automatic logic [CODE_W-1:0] third_code(
      input logic [COORD_W-1:0] ix,
      input logic [COORD_W-1:0] w,
      input logic [COORD_W-1:0] iy,
      input logic [COORD_W-1:0] h
   );
      logic [COORD_W+1:0] ix3;
      logic [COORD_W+1:0] iy3;
      logic [COORD_W+1:0] w1;
      logic [COORD_W+1:0] w2;
      logic [COORD_W+1:0] h1;
      logic [COORD_W+1:0] h2;
      logic [CODE_W-1:0]  code;
      ix3  = {2'b00, ix} + {1'b0, ix, 1'b0};
      iy3  = {2'b00, iy} + {1'b0, iy, 1'b0};
      w1   = {2'b00, w};
      w2   = {1'b0, w, 1'b0};
      h1   = {2'b00, h};
      h2   = {1'b0, h, 1'b0};
      code = '0;
      if (ix3 <= w1) begin
         code = code | CODE_WEST;
      end else if (ix3 >= w2) begin
         code = code | CODE_EAST;
      end
      if (iy3 <= h1) begin
         code = code | CODE_NORTH;
      end else if (iy3 >= h2) begin
         code = code | CODE_SOUTH;
      end
      return code;
   endfunction

endpackage

// ===== sv/sesl_if.sv =====
interface sesl_req_if;
   import sesl_pkg::*;

   logic               valid;
   logic               ready;
   logic [KIND_W-1:0]  kind;
   logic [COORD_W-1:0] rect_x;
   logic [COORD_W-1:0] rect_y;
   logic [COORD_W-1:0] rect_w;
   logic [COORD_W-1:0] rect_h;
   logic [COORD_W-1:0] sample_id;
   logic [COORD_W-1:0] point_x;
   logic [COORD_W-1:0] point_y;

   modport source (
      output valid, kind, rect_x, rect_y, rect_w, rect_h, sample_id, point_x, point_y,
      input  ready
   );
   modport sink (
      input  valid, kind, rect_x, rect_y, rect_w, rect_h, sample_id, point_x, point_y,
      output ready
   );
endinterface

interface sesl_rsp_if;
   import sesl_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [COORD_W-1:0]  found_sample;
   logic [CODE_W-1:0]   sub_location;
   logic                catch_all;
   logic [RANK_W-1:0]   entry_rank;

   modport source (
      output valid, status, found_sample, sub_location, catch_all, entry_rank,
      input  ready
   );
   modport sink (
      input  valid, status, found_sample, sub_location, catch_all, entry_rank,
      output ready
   );
endinterface

// ===== sv/sesl_table.sv =====
module sesl_table #(
   parameter int DEPTH = sesl_pkg::DEF_MAX_SECTORS,
   parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [IDX_W-1:0]         wr_addr,
   input  sesl_pkg::sesl_entry_type wr_data,
   input  logic                     rd_en,
   input  logic [IDX_W-1:0]         rd_addr,
   output sesl_pkg::sesl_entry_type rd_data
);
   import sesl_pkg::*;

   sesl_entry_type mem [DEPTH];
   sesl_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/sesl_ctrl.sv =====
module sesl_ctrl #(
   parameter int MAX_SECTORS = sesl_pkg::DEF_MAX_SECTORS,
   parameter int IDX_W       = (MAX_SECTORS > 1) ? $clog2(MAX_SECTORS) : 1
) (
   input  logic                     clock,
   input  logic                     reset,
   sesl_req_if.sink                 req_bus,
   output logic                     mem_wr_en,
   output logic [IDX_W-1:0]         mem_wr_addr,
   output sesl_pkg::sesl_entry_type mem_wr_data,
   output logic                     mem_rd_en,
   output logic [IDX_W-1:0]         mem_rd_addr,
   input  sesl_pkg::sesl_entry_type mem_rd_data,
   output logic                     res_valid,
   output sesl_pkg::sesl_res_type   res_data,
   input  logic                     res_ready
);
   import sesl_pkg::*;

   localparam int CNT_W  = $clog2(MAX_SECTORS + 1);
   localparam int WIDE_W = (CNT_W > RANK_W) ? CNT_W : RANK_W;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_INS   = 3'd1;
   localparam logic [2:0] S_PLACE = 3'd2;
   localparam logic [2:0] S_QRY   = 3'd3;
   localparam logic [2:0] S_GEO   = 3'd4;
   localparam logic [2:0] S_RESP  = 3'd5;

   logic [2:0]         state_ff,  state_in;
   logic [CNT_W-1:0]   count_ff,  count_in;
   logic [IDX_W-1:0]   k_ff,      k_in;
   sesl_entry_type     new_ff,    new_in;
   logic [AREA_W-1:0]  area_ff,   area_in;
   logic [COORD_W-1:0] px_ff,     px_in;
   logic [COORD_W-1:0] py_ff,     py_in;
   sesl_entry_type     sel_ff,    sel_in;
   logic               catch_ff,  catch_in;
   logic [CNT_W-1:0]   rank_ff,   rank_in;
   sesl_res_type       res_ff,    res_in;

   logic               accept;
   logic [AREA_W-1:0]  rd_area;
   logic               hit;
   logic [COORD_W:0]   x_hi;
   logic [COORD_W:0]   y_hi;
   logic [WIDE_W-1:0]  rank_wide;
   sesl_entry_type     catch_entry;

   assign req_bus.ready = (state_ff == S_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;

   assign rd_area = AREA_W'(mem_rd_data.w) * AREA_W'(mem_rd_data.h);
   assign x_hi    = {1'b0, mem_rd_data.x} + {1'b0, mem_rd_data.w};
   assign y_hi    = {1'b0, mem_rd_data.y} + {1'b0, mem_rd_data.h};
   assign hit     = (px_ff >= mem_rd_data.x) && (py_ff >= mem_rd_data.y) &&
                    ({1'b0, px_ff} <= x_hi) && ({1'b0, py_ff} <= y_hi);

   assign rank_wide   = WIDE_W'(rank_ff);
   assign catch_entry = '{x: '0, y: '0, w: CATCH_ALL_SIZE, h: CATCH_ALL_SIZE, sample: '0};

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      k_in        = k_ff;
      new_in      = new_ff;
      area_in     = area_ff;
      px_in       = px_ff;
      py_in       = py_ff;
      sel_in      = sel_ff;
      catch_in    = catch_ff;
      rank_in     = rank_ff;
      res_in      = res_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = k_ff;
      mem_wr_data = new_ff;
      mem_rd_en   = 1'b0;
      mem_rd_addr = '0;
      res_valid   = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               res_in = '0;
               case (req_bus.kind)
                  KIND_LOAD: begin
                     new_in  = '{x: req_bus.rect_x, y: req_bus.rect_y, w: req_bus.rect_w,
                                 h: req_bus.rect_h, sample: req_bus.sample_id};
                     area_in = AREA_W'(req_bus.rect_w) * AREA_W'(req_bus.rect_h);
                     if (req_bus.rect_w == '0 || req_bus.rect_h == '0) begin
                        res_in.status = ST_SKIPPED;
                        state_in      = S_RESP;
                     end else if (count_ff >= CNT_W'(MAX_SECTORS)) begin
                        res_in.status = ST_FULL;
                        state_in      = S_RESP;
                     end else if (count_ff == '0) begin
                        k_in     = '0;
                        state_in = S_PLACE;
                     end else begin
                        // walk down from the top entry
                        k_in        = IDX_W'(count_ff);
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = IDX_W'(count_ff - CNT_W'(1));
                        state_in    = S_INS;
                     end
                  end
                  KIND_QUERY: begin
                     px_in = req_bus.point_x;
                     py_in = req_bus.point_y;
                     k_in  = '0;
                     if (count_ff == '0) begin
                        sel_in   = catch_entry;
                        catch_in = 1'b1;
                        rank_in  = count_ff;
                        state_in = S_GEO;
                     end else begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = '0;
                        state_in    = S_QRY;
                     end
                  end
                  default: begin
                     count_in      = '0;
                     res_in.status = ST_CLEARED;
                     state_in      = S_RESP;
                  end
               endcase
            end
         end
         S_INS: begin
            mem_wr_en = 1'b1;
            if (rd_area > area_ff) begin
               // shift the larger entry up one slot
               mem_wr_data = mem_rd_data;
               k_in        = k_ff - IDX_W'(1);
               if (k_ff == IDX_W'(1)) begin
                  state_in = S_PLACE;
               end else begin
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = k_ff - IDX_W'(2);
               end
            end else begin
               count_in      = count_ff + CNT_W'(1);
               res_in.status = ST_LOADED;
               state_in      = S_RESP;
            end
         end
         S_PLACE: begin
            mem_wr_en     = 1'b1;
            count_in      = count_ff + CNT_W'(1);
            res_in.status = ST_LOADED;
            state_in      = S_RESP;
         end
         S_QRY: begin
            if (hit) begin
               sel_in   = mem_rd_data;
               catch_in = 1'b0;
               rank_in  = CNT_W'(k_ff);
               state_in = S_GEO;
            end else if (CNT_W'(k_ff) + CNT_W'(1) == count_ff) begin
               sel_in   = catch_entry;
               catch_in = 1'b1;
               rank_in  = count_ff;
               state_in = S_GEO;
            end else begin
               k_in        = k_ff + IDX_W'(1);
               mem_rd_en   = 1'b1;
               mem_rd_addr = k_ff + IDX_W'(1);
            end
         end
         S_GEO: begin
            res_in.status       = ST_ANSWERED;
            res_in.found_sample = sel_ff.sample;
            res_in.sub_location = third_code(px_ff - sel_ff.x, sel_ff.w,
                                             py_ff - sel_ff.y, sel_ff.h);
            res_in.catch_all    = catch_ff;
            res_in.entry_rank   = rank_wide[RANK_W-1:0];
            state_in            = S_RESP;
         end
         S_RESP: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff     <= k_in;
      new_ff   <= new_in;
      area_ff  <= area_in;
      px_ff    <= px_in;
      py_ff    <= py_in;
      sel_ff   <= sel_in;
      catch_ff <= catch_in;
      rank_ff  <= rank_in;
      res_ff   <= res_in;
   end

   assign res_data = res_ff;

   a_write_only_on_load: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> (state_ff == S_INS || state_ff == S_PLACE))
      else $error("table written outside an insert");

   a_no_same_slot: assert property (@(posedge clock) disable iff (reset)
      (mem_wr_en && mem_rd_en) |-> (mem_wr_addr != mem_rd_addr))
      else $error("read and write hit the same slot");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_SECTORS))
      else $error("sector count beyond capacity");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (accept && req_bus.kind[1]) |=> (count_ff == '0))
      else $error("clear did not empty the table");

endmodule

// ===== sv/smallest_enclosing_sector_lookup.sv =====
// Acceptance to result valid at the output: clear, zero-area and full loads go straight
//   to the result state; a stored load shifts each larger entry up one slot, then writes
//   the new one; a query scans up from the smallest entry to a hit or the catch-all.
// Throughput: one item at a time; the single table read port walks one entry per cycle.
//   The next item is taken once the result reaches the output register. Reset empties
//   the table (count only).
module smallest_enclosing_sector_lookup #(
   parameter int MAX_SECTORS = sesl_pkg::DEF_MAX_SECTORS
) (
   input  logic     clock,
   input  logic     reset,
   sesl_req_if.sink   req_bus,
   sesl_rsp_if.source rsp_bus
);
   import sesl_pkg::*;

   localparam int IDX_W = (MAX_SECTORS > 1) ? $clog2(MAX_SECTORS) : 1;

   // table access from the sequencer
   logic             mem_wr_en;
   logic [IDX_W-1:0] mem_wr_addr;
   sesl_entry_type   mem_wr_data;
   logic             mem_rd_en;
   logic [IDX_W-1:0] mem_rd_addr;
   sesl_entry_type   mem_rd_data;

   // finished result from the sequencer
   logic         res_valid;
   logic         res_ready;
   sesl_res_type res_data;

   // output register
   logic         rsp_valid_ff, rsp_valid_in;
   sesl_res_type rsp_data_ff,  rsp_data_in;

   sesl_table #(
      .DEPTH (MAX_SECTORS),
      .IDX_W (IDX_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   sesl_ctrl #(
      .MAX_SECTORS (MAX_SECTORS),
      .IDX_W       (IDX_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .res_valid   (res_valid),
      .res_data    (res_data),
      .res_ready   (res_ready)
   );

   // The output slot frees as soon as the item in it is taken, so the sequencer can
   // hand over the next result in the same cycle.
   assign res_ready = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
      // load a new item; it wins over the drop above
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.status       = rsp_data_ff.status;
   assign rsp_bus.found_sample = rsp_data_ff.found_sample;
   assign rsp_bus.sub_location = rsp_data_ff.sub_location;
   assign rsp_bus.catch_all    = rsp_data_ff.catch_all;
   assign rsp_bus.entry_rank   = rsp_data_ff.entry_rank;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_bus.ready) |=> (rsp_valid_ff && $stable(rsp_data_ff)))
      else $error("pending result overwritten");

   a_one_result_per_item: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res_ready) |=> rsp_valid_ff)
      else $error("finished item not shown at the output");

   a_load_status_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.status != ST_ANSWERED) |->
         (rsp_data_ff.catch_all == 1'b0 && rsp_data_ff.entry_rank == '0))
      else $error("non-query result carries query fields");

endmodule

// ===== bench/tb.sv =====
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sesl_pkg::*;

   // Kind code that the block decodes as a clear; not named in the package.
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   localparam int RANDOM_ITEMS = 1430;
   // The limit covers the worst-case block time, the sender's gap and a receiver stall per
   // item, plus the long hold, several times over.
   localparam int CYCLE_LIMIT  = 900000;
   localparam int HOLD_AFTER   = 400;
   localparam int HOLD_CYCLES  = 600;
   localparam int DRAIN_CYCLES = 80;
   localparam int REPORT_MAX   = 10;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [COORD_W-1:0] rect_x;
      logic [COORD_W-1:0] rect_y;
      logic [COORD_W-1:0] rect_w;
      logic [COORD_W-1:0] rect_h;
      logic [COORD_W-1:0] sample_id;
      logic [COORD_W-1:0] point_x;
      logic [COORD_W-1:0] point_y;
   } sector_req_type;

   localparam int REQ_BITS = $bits(sector_req_type);

   // One row of the directed stimulus; typed rows carry their own answer.
   typedef struct {
      sector_req_type req;
      bit             typed;
      sesl_res_type   res;
   } directed_row_type;

   logic clock;
   logic reset;

   sesl_req_if req_bus ();
   sesl_rsp_if rsp_bus ();

   smallest_enclosing_sector_lookup dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // Local copy of the rectangle table, kept in area order like the block's.
   sesl_entry_type sector_model [DEF_MAX_SECTORS];
   int             model_count = 0;

   // Answers still owed by the block, oldest first.
   sesl_res_type   pending_results [$];
   sesl_res_type   oldest_result;

   int  accepted_items = 0;
   int  burst_left     = 0;
   int  mismatches     = 0;
   int  cycle_count    = 0;
   bit  hold_done      = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Thirds of a span by cross-multiplication: west/north in the first third,
   // east/south in the last, nothing in the middle.
   function automatic logic [CODE_W-1:0] thirds_of(int ix, int w, int iy, int h);
      logic [CODE_W-1:0] code;
      code = '0;
      if (3 * ix <= w) begin
         code = code | CODE_WEST;
      end else if (3 * ix >= 2 * w) begin
         code = code | CODE_EAST;
      end
      if (3 * iy <= h) begin
         code = code | CODE_NORTH;
      end else if (3 * iy >= 2 * h) begin
         code = code | CODE_SOUTH;
      end
      return code;
   endfunction

   // Apply one accepted item to the local table and return the answer it earns.
   function automatic sesl_res_type sector_outcome(sector_req_type r);
      sesl_res_type   res;
      sesl_entry_type e;
      int             area;
      int             pos;
      int             hit;
      res = '0;
      case (r.kind)
         KIND_LOAD: begin
            area = int'(r.rect_w) * int'(r.rect_h);
            if (area == 0) begin
               res.status = ST_SKIPPED;
            end else if (model_count >= DEF_MAX_SECTORS) begin
               res.status = ST_FULL;
            end else begin
               // equal areas land behind the ones already stored
               pos = 0;
               while (pos < model_count &&
                      int'(sector_model[pos].w) * int'(sector_model[pos].h) <= area)
                  pos++;
               for (int k = model_count; k > pos; k--)
                  sector_model[k] = sector_model[k-1];
               sector_model[pos] = '{r.rect_x, r.rect_y, r.rect_w, r.rect_h, r.sample_id};
               model_count++;
               res.status = ST_LOADED;
            end
         end
         KIND_QUERY: begin
            // walk backward so the first containing entry wins
            hit = model_count;
            for (int i = model_count - 1; i >= 0; i--) begin
               e = sector_model[i];
               if (int'(r.point_x) >= int'(e.x) && int'(r.point_y) >= int'(e.y) &&
                   int'(r.point_x) <= int'(e.x) + int'(e.w) &&
                   int'(r.point_y) <= int'(e.y) + int'(e.h))
                  hit = i;
            end
            res.status = ST_ANSWERED;
            if (hit < model_count) begin
               e = sector_model[hit];
               res.found_sample = e.sample;
               res.sub_location = thirds_of(int'(r.point_x) - int'(e.x), int'(e.w),
                                            int'(r.point_y) - int'(e.y), int'(e.h));
               res.entry_rank   = RANK_W'(hit);
            end else begin
               res.sub_location = thirds_of(int'(r.point_x), int'(CATCH_ALL_SIZE),
                                            int'(r.point_y), int'(CATCH_ALL_SIZE));
               res.catch_all    = 1'b1;
               res.entry_rank   = RANK_W'(model_count);
            end
         end
         default: begin
            // clear, and the unused kind that decodes as clear
            model_count = 0;
            res.status  = ST_CLEARED;
         end
      endcase
      return res;
   endfunction

   // Item builders: fields the kind ignores carry random bits.
   function automatic sector_req_type load_req(int x, int y, int w, int h, int s);
      sector_req_type r;
      r = REQ_BITS'({$urandom, $urandom});
      r.kind      = KIND_LOAD;
      r.rect_x    = COORD_W'(x);
      r.rect_y    = COORD_W'(y);
      r.rect_w    = COORD_W'(w);
      r.rect_h    = COORD_W'(h);
      r.sample_id = COORD_W'(s);
      return r;
   endfunction

   function automatic sector_req_type query_req(int px, int py);
      sector_req_type r;
      r = REQ_BITS'({$urandom, $urandom});
      r.kind    = KIND_QUERY;
      r.point_x = COORD_W'(px);
      r.point_y = COORD_W'(py);
      return r;
   endfunction

   function automatic sector_req_type clear_req(logic [KIND_W-1:0] k);
      sector_req_type r;
      r = REQ_BITS'({$urandom, $urandom});
      r.kind = k;
      return r;
   endfunction

   function automatic directed_row_type known(sector_req_type r, logic [STATUS_W-1:0] st,
                                              logic [COORD_W-1:0] smp,
                                              logic [CODE_W-1:0] code,
                                              logic ca, logic [RANK_W-1:0] rank);
      directed_row_type row;
      row.req   = r;
      row.typed = 1'b1;
      row.res   = '{st, smp, code, ca, rank};
      return row;
   endfunction

   function automatic directed_row_type predicted(sector_req_type r);
      directed_row_type row;
      row.req   = r;
      row.typed = 1'b0;
      row.res   = '0;
      return row;
   endfunction

   // Offer one item and hold it until the block takes it. Valid stays high into the
   // next item inside a burst; a gap drops it between items.
   task automatic send_item(sector_req_type r, bit typed, sesl_res_type typed_res);
      sesl_res_type answer;
      int           gap;
      req_bus.valid     <= 1'b1;
      req_bus.kind      <= r.kind;
      req_bus.rect_x    <= r.rect_x;
      req_bus.rect_y    <= r.rect_y;
      req_bus.rect_w    <= r.rect_w;
      req_bus.rect_h    <= r.rect_h;
      req_bus.sample_id <= r.sample_id;
      req_bus.point_x   <= r.point_x;
      req_bus.point_y   <= r.point_y;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      // accepted at this edge: advance the local table right away
      answer = sector_outcome(r);
      pending_results.push_back(typed ? typed_res : answer);
      accepted_items++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = $urandom_range(1, 12);
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                  : $urandom_range(0, 20);
      end
   endtask

   // Receiver: stretches of steady, light and heavy stalling, plus one long hold
   // that backs the block up while the sender keeps offering.
   initial begin : receiver
      int mode;
      int seg_left;
      mode     = 0;
      seg_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         if (!hold_done && accepted_items >= HOLD_AFTER) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1;
         end else begin
            if (seg_left == 0) begin
               mode     = $urandom_range(0, 3);
               seg_left = $urandom_range(20, 300);
            end
            seg_left--;
            case (mode)
               0:       rsp_bus.ready <= 1'b1;
               1:       rsp_bus.ready <= 1'($urandom_range(0, 1));
               2:       rsp_bus.ready <= ($urandom_range(0, 4) == 0);
               default: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
            endcase
            @(posedge clock);
         end
      end
   end

   // Result checker: every accepted answer against the oldest one owed.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("unexpected result: status %0d sample %0d code %0d catch %0d rank %0d",
                        rsp_bus.status, rsp_bus.found_sample, rsp_bus.sub_location,
                        rsp_bus.catch_all, rsp_bus.entry_rank);
         end else begin
            oldest_result = pending_results.pop_front();
            if (rsp_bus.status       !== oldest_result.status       ||
                rsp_bus.found_sample !== oldest_result.found_sample ||
                rsp_bus.sub_location !== oldest_result.sub_location ||
                rsp_bus.catch_all    !== oldest_result.catch_all    ||
                rsp_bus.entry_rank   !== oldest_result.entry_rank) begin
               mismatches++;
               if (mismatches <= REPORT_MAX)
                  $display("mismatch st/smp/code/ca/rank: want %0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d",
                           oldest_result.status, oldest_result.found_sample,
                           oldest_result.sub_location, oldest_result.catch_all,
                           oldest_result.entry_rank, rsp_bus.status, rsp_bus.found_sample,
                           rsp_bus.sub_location, rsp_bus.catch_all, rsp_bus.entry_rank);
            end
         end
      end
   end

   // Watchdog on total run length.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin : stimulus
      directed_row_type rows [$];
      sector_req_type   r;
      sesl_entry_type   e;
      int               random_sent;
      int               phase_loads;
      int               phase_len;
      int               loads_done;
      int               pick;
      int               scale;
      int               px;
      int               py;
      int               idx;

      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.kind      <= '0;
      req_bus.rect_x    <= '0;
      req_bus.rect_y    <= '0;
      req_bus.rect_w    <= '0;
      req_bus.rect_h    <= '0;
      req_bus.sample_id <= '0;
      req_bus.point_x   <= '0;
      req_bus.point_y   <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed part. Empty table: the catch-all answers at its corners.
      rows.push_back(known(query_req(0, 0), ST_ANSWERED, 8'd0, CODE_WEST | CODE_NORTH,
                           1'b1, 7'd0));
      rows.push_back(known(query_req(255, 255), ST_ANSWERED, 8'd0, CODE_EAST | CODE_SOUTH,
                           1'b1, 7'd0));
      rows.push_back(predicted(query_req(128, 84)));
      // zero area is skipped, whichever side is zero
      rows.push_back(known(load_req(1, 2, 0, 9, 3), ST_SKIPPED, 8'd0, 4'd0, 1'b0, 7'd0));
      rows.push_back(known(load_req(1, 2, 9, 0, 3), ST_SKIPPED, 8'd0, 4'd0, 1'b0, 7'd0));
      rows.push_back(known(load_req(0, 0, 0, 0, 0), ST_SKIPPED, 8'd0, 4'd0, 1'b0, 7'd0));
      // loads at the extremes, an equal-area pair, and one that goes to the front
      rows.push_back(known(load_req(10, 10, 20, 20, 5), ST_LOADED, 8'd0, 4'd0, 1'b0, 7'd0));
      rows.push_back(known(load_req(0, 0, 255, 255, 255), ST_LOADED, 8'd0, 4'd0, 1'b0, 7'd0));
      rows.push_back(known(load_req(255, 255, 255, 255, 170), ST_LOADED, 8'd0, 4'd0, 1'b0,
                           7'd0));
      rows.push_back(known(load_req(10, 10, 20, 20, 85), ST_LOADED, 8'd0, 4'd0, 1'b0, 7'd0));
      rows.push_back(known(load_req(5, 5, 1, 1, 7), ST_LOADED, 8'd0, 4'd0, 1'b0, 7'd0));
      rows.push_back(predicted(query_req(10, 10)));
      rows.push_back(predicted(query_req(30, 30)));
      rows.push_back(predicted(query_req(20, 20)));
      rows.push_back(predicted(query_req(6, 5)));
      rows.push_back(predicted(query_req(31, 30)));
      rows.push_back(predicted(query_req(255, 255)));
      rows.push_back(predicted(query_req(0, 255)));
      // the unused kind clears, then the catch-all answers again
      rows.push_back(known(clear_req(KIND_UNUSED), ST_CLEARED, 8'd0, 4'd0, 1'b0, 7'd0));
      rows.push_back(known(query_req(255, 0), ST_ANSWERED, 8'd0, CODE_EAST | CODE_NORTH,
                           1'b1, 7'd0));
      rows.push_back(known(load_req(0, 0, 255, 1, 1), ST_LOADED, 8'd0, 4'd0, 1'b0, 7'd0));
      rows.push_back(predicted(query_req(200, 1)));
      rows.push_back(known(clear_req(KIND_CLEAR), ST_CLEARED, 8'd0, 4'd0, 1'b0, 7'd0));
      foreach (rows[i])
         send_item(rows[i].req, rows[i].typed, rows[i].res);

      // Random part in phases: fill the table (sometimes past full), query it mostly
      // inside stored rectangles, sprinkle noise, and usually clear at the end.
      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         phase_loads = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 72)
                                                   : $urandom_range(1, 14);
         phase_len   = phase_loads + $urandom_range(phase_loads, 2 * phase_loads + 10);
         loads_done  = 0;
         for (int n = 0; n < phase_len; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
               // zero-area load
               if ($urandom_range(0, 1))
                  r = load_req($urandom, $urandom, 0, $urandom, $urandom);
               else
                  r = load_req($urandom, $urandom, $urandom, 0, $urandom);
            end else if (pick < 8) begin
               // anything at all, load or query
               r      = REQ_BITS'({$urandom, $urandom});
               r.kind = $urandom_range(0, 1) ? KIND_QUERY : KIND_LOAD;
            end else if (pick < 55 && loads_done < phase_loads) begin
               case ($urandom_range(0, 3))
                  0:       scale = 4;
                  1:       scale = 16;
                  2:       scale = 64;
                  default: scale = 255;
               endcase
               r = load_req($urandom_range(0, 255), $urandom_range(0, 255),
                            $urandom_range(1, scale), $urandom_range(1, scale),
                            $urandom_range(0, 255));
               loads_done++;
            end else if (model_count > 0 && pick < 92) begin
               // aim at a stored rectangle: its corners, just outside, or inside
               idx = $urandom_range(0, model_count - 1);
               e   = sector_model[idx];
               px  = int'(e.x) + $urandom_range(0, e.w);
               py  = int'(e.y) + $urandom_range(0, e.h);
               case ($urandom_range(0, 5))
                  0: begin
                     px = int'(e.x);
                     py = int'(e.y);
                  end
                  1: begin
                     px = int'(e.x) + int'(e.w);
                     py = int'(e.y) + int'(e.h);
                  end
                  2: px = (e.x > 0) ? int'(e.x) - 1 : 0;
                  3: py = int'(e.y) + int'(e.h) + 1;
                  default: ;
               endcase
               r = query_req((px > 255) ? 255 : px, (py > 255) ? 255 : py);
            end else begin
               r = query_req($urandom_range(0, 255), $urandom_range(0, 255));
            end
            send_item(r, 1'b0, '0);
            random_sent++;
         end
         if ($urandom_range(0, 4) != 0) begin
            r = clear_req(($urandom_range(0, 3) == 0) ? KIND_UNUSED : KIND_CLEAR);
            send_item(r, 1'b0, '0);
            random_sent++;
         end
      end
      req_bus.valid <= 1'b0;

      // Drain: wait out every owed answer, then a little longer for strays.
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
